/* hdl/acir_pkg.sv */
// Shared types, widths and constants for the box contact impulse resolver.
// Used by acir_front, acir_div and aabb_contact_impulse_resolver; depends on nothing.
package acir_pkg;

  localparam int LW = 16;
  localparam int CW = 48;
  localparam int UW = 17;
  localparam int AW = 28;
  localparam int PW = 46;
  localparam int MW = 45;
  localparam int DW = 26;
  localparam int QW = 17;
  localparam int DIV_LAT = QW + 1;
  localparam int PIPE_LAT = 3 + 1 + DIV_LAT + 1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic            hit;
    logic [2:0][16:0] ov;
    logic [2:0][17:0] cd;
    logic [CW-1:0]   vel1;
    logic [CW-1:0]   vel2;
    logic            st1;
    logic            st2;
    logic            mnz;
    logic signed [AW-1:0] a1;
    logic signed [AW-1:0] b1;
    logic signed [AW-1:0] a2;
    logic signed [AW-1:0] b2;
    logic [DW-1:0]   den;
  } geo_t;

  typedef struct packed {
    logic            hit;
    logic            applied;
    logic [1:0]      ax;
    logic            neg;
    logic            st1;
    logic            st2;
    logic [CW-1:0]   vel1;
    logic [CW-1:0]   vel2;
    logic signed [UW-1:0] u1;
    logic signed [UW-1:0] u2;
    logic signed [AW-1:0] a1;
    logic signed [AW-1:0] b1;
    logic signed [AW-1:0] a2;
    logic signed [AW-1:0] b2;
    logic [DW-1:0]   den;
  } proj_t;

  typedef struct packed {
    logic            hit;
    logic            applied;
    logic [1:0]      ax;
    logic            neg;
    logic            st1;
    logic            st2;
    logic [CW-1:0]   vel1;
    logic [CW-1:0]   vel2;
    logic signed [PW-1:0] pa1;
    logic signed [PW-1:0] pb1;
    logic signed [PW-1:0] pa2;
    logic signed [PW-1:0] pb2;
    logic [DW-1:0]   den;
  } front_t;

  typedef struct packed {
    logic          hit;
    logic          applied;
    logic [1:0]    ax;
    logic          neg;
    logic          st1;
    logic          st2;
    logic [CW-1:0] vel1;
    logic [CW-1:0] vel2;
    logic          nneg1;
    logic          nneg2;
  } side_t;

  function automatic logic signed [LW-1:0] lane16(input logic [CW-1:0] w, input int k);
    return signed'(w[LW*k +: LW]);
  endfunction

endpackage

/* hdl/acir_front.sv */
// Front pipeline: overlap test, contact axis and normal, mass terms and products.
// Three register stages; depends on acir_pkg.
module acir_front import acir_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [CW-1:0] box_one_min,
  input  logic [CW-1:0] box_one_max,
  input  logic [CW-1:0] box_two_min,
  input  logic [CW-1:0] box_two_max,
  input  logic [CW-1:0] vel_one,
  input  logic [CW-1:0] vel_two,
  input  logic [15:0]   mass_one,
  input  logic [15:0]   mass_two,
  input  logic [8:0]    bounce_one,
  input  logic [8:0]    bounce_two,
  input  logic          fixed_one,
  input  logic          fixed_two,
  output logic          out_valid,
  output front_t        out_data
);

  geo_t   s1_nxt, s1_r;
  proj_t  s2_nxt, s2_r;
  front_t s3_nxt, s3_r;
  logic   v1_r, v2_r, v3_r;

  always_comb begin
    logic signed [LW-1:0] lo1, hi1, lo2, hi2, top, bot;
    logic [9:0]  e2;
    logic [10:0] e2p;
    logic [25:0] e2m1, e2m2;
    logic [26:0] b1u, b2u;
    logic [16:0] msum;
    s1_nxt.hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      lo1 = lane16(box_one_min, k);
      hi1 = lane16(box_one_max, k);
      lo2 = lane16(box_two_min, k);
      hi2 = lane16(box_two_max, k);
      if (!((lo1 <= hi2) && (hi1 >= lo2))) begin
        s1_nxt.hit = 1'b0;
      end
      top = (hi1 < hi2) ? hi1 : hi2;
      bot = (lo1 > lo2) ? lo1 : lo2;
      s1_nxt.ov[k] = 17'(top) - 17'(bot);
      s1_nxt.cd[k] = (18'(lo2) + 18'(hi2)) - (18'(lo1) + 18'(hi1));
    end
    e2   = {1'b0, bounce_one} + {1'b0, bounce_two};
    e2p  = {1'b0, e2} + 11'd512;
    e2m1 = e2 * mass_one;
    e2m2 = e2 * mass_two;
    b1u  = e2p * mass_two;
    b2u  = e2p * mass_one;
    msum = {1'b0, mass_one} + {1'b0, mass_two};
    s1_nxt.a1   = $signed({3'b0, mass_one, 9'b0}) - $signed({2'b0, e2m2});
    s1_nxt.a2   = $signed({3'b0, mass_two, 9'b0}) - $signed({2'b0, e2m1});
    s1_nxt.b1   = $signed({1'b0, b1u});
    s1_nxt.b2   = $signed({1'b0, b2u});
    s1_nxt.den  = {msum, 9'b0};
    s1_nxt.mnz  = (msum != 17'd0);
    s1_nxt.vel1 = vel_one;
    s1_nxt.vel2 = vel_two;
    s1_nxt.st1  = fixed_one;
    s1_nxt.st2  = fixed_two;
  end

  always_comb begin
    logic signed [16:0] ov0, ov1, ov2;
    logic signed [17:0] cds, rel;
    logic signed [LW-1:0] va, vb;
    ov0 = $signed(s1_r.ov[0]);
    ov1 = $signed(s1_r.ov[1]);
    ov2 = $signed(s1_r.ov[2]);
    priority if ((ov0 < ov1) && (ov0 < ov2)) begin
      s2_nxt.ax = AXIS_X;
    end else if ((ov1 < ov0) && (ov1 < ov2)) begin
      s2_nxt.ax = AXIS_Y;
    end else begin
      s2_nxt.ax = AXIS_Z;
    end
    cds = $signed(s1_r.cd[s2_nxt.ax]);
    va  = lane16(s1_r.vel1, int'(s2_nxt.ax));
    vb  = lane16(s1_r.vel2, int'(s2_nxt.ax));
    s2_nxt.neg = (cds < 0);
    s2_nxt.u1  = s2_nxt.neg ? -17'(va) : 17'(va);
    s2_nxt.u2  = s2_nxt.neg ? -17'(vb) : 17'(vb);
    rel = 18'(s2_nxt.u2) - 18'(s2_nxt.u1);
    s2_nxt.applied = s1_r.hit && !(s1_r.st1 && s1_r.st2) && (rel <= 0) && s1_r.mnz;
    s2_nxt.hit  = s1_r.hit;
    s2_nxt.st1  = s1_r.st1;
    s2_nxt.st2  = s1_r.st2;
    s2_nxt.vel1 = s1_r.vel1;
    s2_nxt.vel2 = s1_r.vel2;
    s2_nxt.a1   = s1_r.a1;
    s2_nxt.b1   = s1_r.b1;
    s2_nxt.a2   = s1_r.a2;
    s2_nxt.b2   = s1_r.b2;
    s2_nxt.den  = s1_r.den;
  end

  always_comb begin
    s3_nxt.hit     = s2_r.hit;
    s3_nxt.applied = s2_r.applied;
    s3_nxt.ax      = s2_r.ax;
    s3_nxt.neg     = s2_r.neg;
    s3_nxt.st1     = s2_r.st1;
    s3_nxt.st2     = s2_r.st2;
    s3_nxt.vel1    = s2_r.vel1;
    s3_nxt.vel2    = s2_r.vel2;
    s3_nxt.pa1     = s2_r.a1 * s2_r.u1;
    s3_nxt.pb1     = s2_r.b1 * s2_r.u2;
    s3_nxt.pa2     = s2_r.a2 * s2_r.u2;
    s3_nxt.pb2     = s2_r.b2 * s2_r.u1;
    s3_nxt.den     = s2_r.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

/* hdl/acir_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on acir_pkg.
module acir_div import acir_pkg::*; (
  input  logic          clk,
  input  logic [MW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [MW-1:0] r_r [0:QW-1];
  logic [DW-1:0] d_r [0:QW-1];
  logic [QW-1:0] q_r [0:QW];
  logic          o_r [0:QW];

  always_ff @(posedge clk) begin
    r_r[0] <= num;
    d_r[0] <= den;
    q_r[0] <= '0;
    o_r[0] <= (num >= MW'({den, {QW{1'b0}}}));
  end

  for (genvar i = 1; i <= QW; i++) begin : g_stage
    localparam int B = QW - i;
    logic [MW-1:0] sh;
    logic          take;
    assign sh   = MW'(d_r[i-1]) << B;
    assign take = !o_r[i-1] && (r_r[i-1] >= sh);
    always_ff @(posedge clk) begin
      q_r[i] <= q_r[i-1] | (take ? (QW'(1) << B) : QW'(0));
      o_r[i] <= o_r[i-1];
    end
    if (i < QW) begin : g_carry
      always_ff @(posedge clk) begin
        r_r[i] <= take ? (r_r[i-1] - sh) : r_r[i-1];
        d_r[i] <= d_r[i-1];
      end
    end
  end

  assign quo = o_r[QW] ? {QW{1'b1}} : q_r[QW];

endmodule

/* hdl/aabb_contact_impulse_resolver.sv */
// Box pair contact impulse resolver: front pipeline, two dividers, output stage.
// Depends on acir_pkg, acir_front and acir_div.
//
// One request is accepted every clock cycle; busy is always low. Each request
// gives exactly one result, marked by out_valid for a single cycle. The two
// 17-stage restoring dividers produce one quotient bit per stage. The receiver
// cannot stall the block, so results must be taken the cycle they appear.
module aabb_contact_impulse_resolver import acir_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [CW-1:0] in_box_one_min,
  input  logic [CW-1:0] in_box_one_max,
  input  logic [CW-1:0] in_box_two_min,
  input  logic [CW-1:0] in_box_two_max,
  input  logic [CW-1:0] in_vel_one,
  input  logic [CW-1:0] in_vel_two,
  input  logic [15:0]   in_mass_one,
  input  logic [15:0]   in_mass_two,
  input  logic [8:0]    in_bounce_one,
  input  logic [8:0]    in_bounce_two,
  input  logic          in_fixed_one,
  input  logic          in_fixed_two,
  output logic          out_valid,
  output logic          out_overlap,
  output logic          out_applied,
  output logic [1:0]    out_contact_axis,
  output logic          out_normal_negative,
  output logic [CW-1:0] out_new_vel_one,
  output logic [CW-1:0] out_new_vel_two
);

  logic          fr_valid;
  front_t        fr_data;
  side_t         side_nxt;
  side_t         side_r [0:DIV_LAT];
  logic          sv_r   [0:DIV_LAT];
  logic [MW-1:0] mag1_r, mag2_r, mag1_nxt, mag2_nxt;
  logic [DW-1:0] den_r;
  logic [QW-1:0] q1, q2;
  logic [CW-1:0] v1_nxt, v2_nxt, v1_r, v2_r;
  logic          ov_r, ap_r, ng_r, val_r;
  logic [1:0]    ax_r;

  assign busy = 1'b0;

  acir_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .box_one_min(in_box_one_min),
    .box_one_max(in_box_one_max),
    .box_two_min(in_box_two_min),
    .box_two_max(in_box_two_max),
    .vel_one    (in_vel_one),
    .vel_two    (in_vel_two),
    .mass_one   (in_mass_one),
    .mass_two   (in_mass_two),
    .bounce_one (in_bounce_one),
    .bounce_two (in_bounce_two),
    .fixed_one  (in_fixed_one),
    .fixed_two  (in_fixed_two),
    .out_valid  (fr_valid),
    .out_data   (fr_data)
  );

  always_comb begin
    logic signed [PW-1:0] n1, n2;
    n1 = fr_data.pa1 + fr_data.pb1;
    n2 = fr_data.pa2 + fr_data.pb2;
    mag1_nxt = MW'(n1[PW-1] ? -n1 : n1);
    mag2_nxt = MW'(n2[PW-1] ? -n2 : n2);
    side_nxt.hit     = fr_data.hit;
    side_nxt.applied = fr_data.applied;
    side_nxt.ax      = fr_data.ax;
    side_nxt.neg     = fr_data.neg;
    side_nxt.st1     = fr_data.st1;
    side_nxt.st2     = fr_data.st2;
    side_nxt.vel1    = fr_data.vel1;
    side_nxt.vel2    = fr_data.vel2;
    side_nxt.nneg1   = n1[PW-1];
    side_nxt.nneg2   = n2[PW-1];
  end

  always_ff @(posedge clk) begin
    mag1_r    <= mag1_nxt;
    mag2_r    <= mag2_nxt;
    den_r     <= fr_data.den;
    side_r[0] <= side_nxt;
    for (int k = 1; k <= DIV_LAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_LAT; k++) begin
        sv_r[k] <= 1'b0;
      end
      val_r <= 1'b0;
    end else begin
      sv_r[0] <= fr_valid;
      for (int k = 1; k <= DIV_LAT; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
      val_r <= sv_r[DIV_LAT];
    end
  end

  acir_div u_div_one (
    .clk(clk),
    .num(mag1_r),
    .den(den_r),
    .quo(q1)
  );

  acir_div u_div_two (
    .clk(clk),
    .num(mag2_r),
    .den(den_r),
    .quo(q2)
  );

  function automatic logic [LW-1:0] fin(input logic [QW-1:0] q, input logic negr);
    logic [QW-1:0] m;
    m = -q;
    if (!negr) begin
      return (q > QW'(32767)) ? 16'h7fff : q[LW-1:0];
    end
    return (q > QW'(32768)) ? 16'h8000 : m[LW-1:0];
  endfunction

  always_comb begin
    side_t s;
    s = side_r[DIV_LAT];
    v1_nxt = s.vel1;
    v2_nxt = s.vel2;
    if (s.applied && !s.st1) begin
      v1_nxt[LW*int'(s.ax) +: LW] = fin(q1, s.nneg1 ^ s.neg);
    end
    if (s.applied && !s.st2) begin
      v2_nxt[LW*int'(s.ax) +: LW] = fin(q2, s.nneg2 ^ s.neg);
    end
  end

  always_ff @(posedge clk) begin
    v1_r <= v1_nxt;
    v2_r <= v2_nxt;
    ov_r <= side_r[DIV_LAT].hit;
    ap_r <= side_r[DIV_LAT].applied;
    ax_r <= side_r[DIV_LAT].ax;
    ng_r <= side_r[DIV_LAT].neg;
  end

  assign out_valid           = val_r;
  assign out_overlap         = ov_r;
  assign out_applied         = ap_r;
  assign out_contact_axis    = ax_r;
  assign out_normal_negative = ng_r;
  assign out_new_vel_one     = v1_r;
  assign out_new_vel_two     = v2_r;

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("Result without a matching request.");

  a_applied_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_applied) |-> out_overlap)
    else $error("Impulse applied without overlap.");

  a_pass_through_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_applied) |-> (out_new_vel_one == $past(in_vel_one, PIPE_LAT)))
    else $error("Velocity of body one altered without impulse.");

  a_pass_through_two: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_applied) |-> (out_new_vel_two == $past(in_vel_two, PIPE_LAT)))
    else $error("Velocity of body two altered without impulse.");

  a_static_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_applied) |->
      !($past(in_fixed_one, PIPE_LAT) && $past(in_fixed_two, PIPE_LAT)))
    else $error("Impulse applied to a pair of static bodies.");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for aabb_contact_impulse_resolver.
// Predicts each contact result in SystemVerilog and compares every output strobe;
// depends on acir_pkg and the resolver RTL.
module tb_top import acir_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n, start, busy;
  logic [CW-1:0] in_box_one_min, in_box_one_max, in_box_two_min, in_box_two_max;
  logic [CW-1:0] in_vel_one, in_vel_two;
  logic [15:0] in_mass_one, in_mass_two;
  logic [8:0] in_bounce_one, in_bounce_two;
  logic in_fixed_one, in_fixed_two;
  logic out_valid, out_overlap, out_applied, out_normal_negative;
  logic [1:0] out_contact_axis;
  logic [CW-1:0] out_new_vel_one, out_new_vel_two;

  typedef struct packed {
    logic [CW-1:0] lo1, hi1, lo2, hi2, v1, v2;
    logic [15:0] m1, m2;
    logic [8:0] e1, e2;
    logic s1, s2;
  } contact_req_t;

  typedef struct packed {
    logic hit, applied;
    logic [1:0] ax;
    logic neg;
    logic [CW-1:0] nv1, nv2;
  } contact_res_t;

  contact_res_t expected_contacts[$];
  int errors = 0;
  int idle_pct = 0;

  aabb_contact_impulse_resolver dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("aabb_contact_impulse_resolver test failed");
    $finish;
  end

  function automatic logic signed [15:0] comp(input logic [CW-1:0] w, input int k);
    return w[16*k +: 16];
  endfunction

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic contact_res_t resolve_contact(input contact_req_t r);
    contact_res_t o;
    int ov[3];
    int a1, b1, a2, b2, top, bot, sg, u1, u2, ax, cd;
    longint m1, m2, e, den, n1, n2;
    logic hit;
    logic [CW-1:0] va, vb;
    hit = 1;
    for (int k = 0; k < 3; k++) begin
      a1 = comp(r.lo1, k); b1 = comp(r.hi1, k);
      a2 = comp(r.lo2, k); b2 = comp(r.hi2, k);
      if (!(a1 <= b2 && b1 >= a2)) hit = 0;
      top = b1 < b2 ? b1 : b2;
      bot = a1 > a2 ? a1 : a2;
      ov[k] = top - bot;
    end
    if (ov[0] < ov[1] && ov[0] < ov[2]) ax = 0;
    else if (ov[1] < ov[0] && ov[1] < ov[2]) ax = 1;
    else ax = 2;
    cd = (int'(comp(r.lo2, ax)) + int'(comp(r.hi2, ax)))
       - (int'(comp(r.lo1, ax)) + int'(comp(r.hi1, ax)));
    sg = cd < 0 ? -1 : 1;
    u1 = sg * int'(comp(r.v1, ax));
    u2 = sg * int'(comp(r.v2, ax));
    m1 = r.m1; m2 = r.m2; e = longint'(r.e1) + longint'(r.e2);
    va = r.v1; vb = r.v2;
    o.applied = hit && !(r.s1 && r.s2) && (u2 - u1) <= 0 && (m1 + m2) != 0;
    if (o.applied) begin
      den = 512 * (m1 + m2);
      n1 = (512 * m1 - e * m2) * longint'(u1) + (e + 512) * m2 * longint'(u2);
      n2 = (512 * m2 - e * m1) * longint'(u2) + (e + 512) * m1 * longint'(u1);
      if (!r.s1) va[16*ax +: 16] = clamp16(sg * (n1 / den));
      if (!r.s2) vb[16*ax +: 16] = clamp16(sg * (n2 / den));
    end
    o.hit = hit; o.ax = ax[1:0]; o.neg = cd < 0; o.nv1 = va; o.nv2 = vb;
    return o;
  endfunction

  task automatic send_contact(input contact_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk);
    end
    in_box_one_min <= r.lo1; in_box_one_max <= r.hi1;
    in_box_two_min <= r.lo2; in_box_two_max <= r.hi2;
    in_vel_one <= r.v1; in_vel_two <= r.v2;
    in_mass_one <= r.m1; in_mass_two <= r.m2;
    in_bounce_one <= r.e1; in_bounce_two <= r.e2;
    in_fixed_one <= r.s1; in_fixed_two <= r.s2;
    start <= 1;
    do @(posedge clk); while (busy);
    expected_contacts = {expected_contacts, resolve_contact(r)};
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    contact_res_t g, a;
    if (rst_n && out_valid) begin
      a = '{out_overlap, out_applied, out_contact_axis, out_normal_negative,
            out_new_vel_one, out_new_vel_two};
      if (expected_contacts.size() == 0) begin
        $display("%t unexpected result %h", $time, a);
        errors++;
      end else begin
        g = expected_contacts.pop_front();
        if (a.hit !== g.hit)
          $display("%t overlap exp %b got %b", $time, g.hit, a.hit);
        if (a.applied !== g.applied)
          $display("%t applied exp %b got %b", $time, g.applied, a.applied);
        if (a.ax !== g.ax)
          $display("%t contact_axis exp %0d got %0d", $time, g.ax, a.ax);
        if (a.neg !== g.neg)
          $display("%t normal_negative exp %b got %b", $time, g.neg, a.neg);
        if (a.nv1 !== g.nv1)
          $display("%t new_vel_one exp %h got %h", $time, g.nv1, a.nv1);
        if (a.nv2 !== g.nv2)
          $display("%t new_vel_two exp %h got %h", $time, g.nv2, a.nv2);
        if (a !== g) errors++;
      end
    end
  end

  function automatic logic [CW-1:0] rand48();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] near16();
    return 16'($signed($urandom_range(1200)) - 600);
  endfunction

  // Nearby boxes that may overlap, with random velocities and random physics fields.
  function automatic contact_req_t colliding_pair();
    contact_req_t r;
    logic [15:0] a, b, c, d;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      a = near16(); b = a + 16'($urandom_range(800));
      c = a + 16'($urandom_range(900)) - 16'd100; d = c + 16'($urandom_range(800));
      r.lo1[16*k +: 16] = a; r.hi1[16*k +: 16] = b;
      r.lo2[16*k +: 16] = c; r.hi2[16*k +: 16] = d;
    end
    r.v1 = rand48(); r.v2 = rand48();
    if ($urandom_range(1)) begin
      for (int k = 0; k < 3; k++) begin
        r.v1[16*k +: 16] = near16(); r.v2[16*k +: 16] = near16();
      end
    end
    r.m1 = $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(2048, 1));
    r.m2 = $urandom_range(3) == 0 ? 16'($urandom()) : 16'($urandom_range(2048, 1));
    if ($urandom_range(30) == 0) r.m1 = 0;
    r.e1 = $urandom_range(5) == 0 ? 9'($urandom()) : 9'($urandom_range(256));
    r.e2 = $urandom_range(5) == 0 ? 9'($urandom()) : 9'($urandom_range(256));
    r.s1 = $urandom_range(4) == 0; r.s2 = $urandom_range(4) == 0;
    return r;
  endfunction

  function automatic contact_req_t noise_pair();
    contact_req_t r;
    r = {rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
         16'($urandom()), 16'($urandom()), 9'($urandom()), 9'($urandom()),
         1'($urandom()), 1'($urandom())};
    return r;
  endfunction

  task automatic drain_results();
    start <= 0;
    while (expected_contacts.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 5) @(negedge clk);
  endtask

  task automatic test_directed();
    contact_req_t r;
    r = colliding_pair(); r.s1 = 1; r.s2 = 1; send_contact(r);
    r = colliding_pair(); r.m1 = 0; r.m2 = 0; send_contact(r);
    r = colliding_pair(); r.m1 = 16'hffff; r.m2 = 16'hffff;
    r.e1 = 9'h1ff; r.e2 = 9'h1ff; send_contact(r);
    r = colliding_pair(); r.e1 = 0; r.e2 = 0; r.s1 = 0; r.s2 = 0; send_contact(r);
    r = colliding_pair(); r.e1 = 256; r.e2 = 256; send_contact(r);
    r = colliding_pair(); r.v1 = {3{16'h7fff}}; r.v2 = {3{16'h8000}};
    r.s1 = 0; r.s2 = 0; send_contact(r);
    r = colliding_pair(); r.v1 = {3{16'h8000}}; r.v2 = {3{16'h7fff}}; send_contact(r);
    r = colliding_pair(); r.v1 = r.v2; send_contact(r);
    r = colliding_pair(); r.lo1 = r.lo2; r.hi1 = r.hi2; send_contact(r);
    r = colliding_pair(); r.lo2 = r.hi1; send_contact(r);
    r = colliding_pair(); r.lo1 = {3{16'h8000}}; r.hi1 = {3{16'h7fff}};
    r.lo2 = {3{16'h8000}}; r.hi2 = {3{16'h7fff}}; send_contact(r);
    r = colliding_pair(); r.lo1 = {3{16'h0100}}; r.hi1 = {3{16'h0000}}; send_contact(r);
    r = colliding_pair(); r.lo2 = {3{16'h7fff}}; r.hi2 = {3{16'h7fff}}; send_contact(r);
    r = '1; send_contact(r);
    r = '0; send_contact(r);
    r = colliding_pair(); r.m1 = 1; r.m2 = 16'hffff; r.s1 = 0; send_contact(r);
    drain_results();
  endtask

  task automatic test_random_phase(input int pct, input int count);
    idle_pct = pct;
    repeat (count) send_contact($urandom_range(9) < 8 ? colliding_pair() : noise_pair());
    idle_pct = 0;
  endtask

  task automatic test_pause_until_drained();
    repeat (20) send_contact(colliding_pair());
    drain_results();
    repeat (20) send_contact(colliding_pair());
  endtask

  initial begin
    rst_n = 0; start = 0;
    {in_box_one_min, in_box_one_max, in_box_two_min, in_box_two_max} = '0;
    {in_vel_one, in_vel_two, in_mass_one, in_mass_two} = '0;
    {in_bounce_one, in_bounce_two, in_fixed_one, in_fixed_two} = '0;
    repeat (7) @(negedge clk);
    rst_n = 1;
    test_directed();
    test_random_phase(0, 365);
    test_random_phase(50, 365);
    test_random_phase(10, 365);
    test_pause_until_drained();
    drain_results();
    if (errors == 0) begin
      $display("aabb_contact_impulse_resolver test passed");
    end else begin
      $display("aabb_contact_impulse_resolver test failed");
    end
    $finish;
  end
endmodule
